// ----- rtl/quoted_argument_tokenizer_unit_macros.svh -----
`ifndef QUOTED_ARGUMENT_TOKENIZER_UNIT_MACROS_SVH
`define QUOTED_ARGUMENT_TOKENIZER_UNIT_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define QAT_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define QAT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/qat_pkg.sv -----
package qat_pkg;

  localparam logic [7:0] CH_NUL      = 8'h00;
  localparam logic [7:0] CH_DQUOTE   = 8'h22;
  localparam logic [7:0] CH_SQUOTE   = 8'h27;
  localparam logic [7:0] CH_BACKTICK = 8'h60;
  localparam logic [7:0] CH_ESC      = 8'h1b;
  localparam logic [7:0] CH_LF       = 8'h0a;
  localparam logic [7:0] CH_NBSP     = 8'ha0;
  localparam logic [7:0] ESCAPE_RESET = 8'h2a;

  typedef struct packed {
    logic       is_nul;
    logic       is_blank;
    logic       is_mark;
    logic       is_open;
    logic       is_esc;
    logic [7:0] xlat;
  } cls_t;

  typedef struct packed {
    logic        text_valid;
    logic [7:0]  text_byte;
    logic        arg_start;
    logic        arg_end;
    logic        unterminated;
    logic        line_done;
    logic [15:0] arg_count;
  } result_t;

endpackage

// ----- rtl/qat_if.sv -----
interface qat_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

interface qat_out_if;
  logic        valid;
  logic        ready;
  logic        text_valid;
  logic [7:0]  text_byte;
  logic        arg_start;
  logic        arg_end;
  logic        unterminated;
  logic        line_done;
  logic [15:0] arg_count;

  modport source (output valid, output text_valid, output text_byte, output arg_start,
                  output arg_end, output unterminated, output line_done, output arg_count,
                  input ready);
  modport sink   (input valid, input text_valid, input text_byte, input arg_start,
                  input arg_end, input unterminated, input line_done, input arg_count,
                  output ready);
endinterface

// ----- rtl/qat_decode.sv -----
module qat_decode (
  input  logic [7:0]   byte_i,
  input  logic [7:0]   open_mark_i,
  input  logic [7:0]   escape_i,
  output qat_pkg::cls_t cls_o
);
  import qat_pkg::*;

  always_comb begin
    cls_o.is_nul   = (byte_i == CH_NUL);
    cls_o.is_blank = byte_i inside {8'h09, 8'h0a, 8'h0b, 8'h0c, 8'h0d, 8'h20, CH_NBSP};
    cls_o.is_mark  = byte_i inside {CH_DQUOTE, CH_SQUOTE, CH_BACKTICK};
    cls_o.is_open  = (byte_i == open_mark_i);
    cls_o.is_esc   = (byte_i == escape_i);
    case (byte_i)
      8'h65, 8'h45: cls_o.xlat = CH_ESC;
      8'h6e, 8'h4e: cls_o.xlat = CH_LF;
      default:      cls_o.xlat = byte_i;
    endcase
  end

endmodule

// ----- rtl/qat_core.sv -----
module qat_core (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             step_i,
  input  logic [7:0]       byte_i,
  input  logic [7:0]       escape_i,
  output qat_pkg::result_t res_o
);
  import qat_pkg::*;

  localparam logic [1:0] MODE_BETWEEN = 2'd0;
  localparam logic [1:0] MODE_PLAIN   = 2'd1;
  localparam logic [1:0] MODE_QUOTED  = 2'd2;
  localparam logic [1:0] MODE_ESCAPED = 2'd3;

  logic [1:0]  mode_r, mode_nxt;
  logic [7:0]  open_mark_r, open_mark_nxt;
  logic [15:0] args_r, args_nxt, args_inc;
  cls_t        cls;

  qat_decode u_decode (
    .byte_i      (byte_i),
    .open_mark_i (open_mark_r),
    .escape_i    (escape_i),
    .cls_o       (cls)
  );

  assign args_inc = (args_r == 16'hffff) ? args_r : args_r + 16'd1;

  always_comb begin
    mode_nxt      = mode_r;
    open_mark_nxt = open_mark_r;
    args_nxt      = args_r;
    res_o         = '0;
    case (mode_r)
      MODE_BETWEEN: begin
        if (cls.is_nul) begin
          res_o.line_done = 1'b1;
        end else if (cls.is_blank) begin
          mode_nxt = MODE_BETWEEN;
        end else if (cls.is_mark) begin
          res_o.arg_start = 1'b1;
          args_nxt        = args_inc;
          open_mark_nxt   = byte_i;
          mode_nxt        = MODE_QUOTED;
        end else begin
          res_o.arg_start  = 1'b1;
          args_nxt         = args_inc;
          res_o.text_valid = 1'b1;
          res_o.text_byte  = byte_i;
          mode_nxt         = MODE_PLAIN;
        end
      end
      MODE_PLAIN: begin
        if (cls.is_nul) begin
          res_o.arg_end   = 1'b1;
          res_o.line_done = 1'b1;
        end else if (cls.is_blank) begin
          res_o.arg_end = 1'b1;
          mode_nxt      = MODE_BETWEEN;
        end else begin
          res_o.text_valid = 1'b1;
          res_o.text_byte  = byte_i;
        end
      end
      MODE_QUOTED: begin
        if (cls.is_nul) begin
          res_o.arg_end      = 1'b1;
          res_o.unterminated = 1'b1;
          res_o.line_done    = 1'b1;
        end else if (cls.is_open) begin
          res_o.arg_end = 1'b1;
          mode_nxt      = MODE_BETWEEN;
        end else if (cls.is_esc) begin
          mode_nxt = MODE_ESCAPED;
        end else begin
          res_o.text_valid = 1'b1;
          res_o.text_byte  = byte_i;
        end
      end
      MODE_ESCAPED: begin
        res_o.text_valid = 1'b1;
        if (cls.is_nul) begin
          res_o.text_byte    = escape_i;
          res_o.arg_end      = 1'b1;
          res_o.unterminated = 1'b1;
          res_o.line_done    = 1'b1;
        end else begin
          res_o.text_byte = cls.xlat;
          mode_nxt        = MODE_QUOTED;
        end
      end
      default: begin
        mode_nxt = MODE_BETWEEN;
      end
    endcase
    res_o.arg_count = args_nxt;
    // end of line returns to the reset state
    if (res_o.line_done) begin
      mode_nxt      = MODE_BETWEEN;
      open_mark_nxt = CH_NUL;
      args_nxt      = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= MODE_BETWEEN;
      open_mark_r <= CH_NUL;
      args_r      <= '0;
    end else if (step_i) begin
      mode_r      <= mode_nxt;
      open_mark_r <= open_mark_nxt;
      args_r      <= args_nxt;
    end
  end

endmodule

// ----- rtl/quoted_argument_tokenizer_unit.sv -----
// path: an input byte is held in the input register, and its result in the result register
// throughput: one byte per cycle if not stalled; scan updates once per byte in a single pass
// a stalled result register holds and the input register keeps accepting until both are full
// reset: synchronous active-low rst_n clears both valid flags, the scan state and the count
// reset also loads the escape byte with 0x2a; no clearing pass
`include "quoted_argument_tokenizer_unit_macros.svh"

module quoted_argument_tokenizer_unit (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic [7:0] cfg_wdata,
  qat_in_if.sink     in_ch,
  qat_out_if.source  out_ch
);
  import qat_pkg::*;

  logic       s1_valid_r;
  logic [7:0] s1_byte_r;
  logic       out_valid_r;
  result_t    out_data_r;
  result_t    res;
  logic [7:0] escape_r;
  logic       adv_out;
  logic       in_ready;
  logic       step;

  assign adv_out  = !out_valid_r || out_ch.ready;
  assign in_ready = !s1_valid_r || adv_out;
  assign step     = s1_valid_r && adv_out;

  assign in_ch.ready = in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      escape_r <= ESCAPE_RESET;
    end else if (cfg_we) begin
      escape_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_ch.valid) begin
      s1_byte_r <= in_ch.in_byte;
    end
  end

  qat_core u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .step_i   (step),
    .byte_i   (s1_byte_r),
    .escape_i (escape_r),
    .res_o    (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv_out) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_data_r <= res;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.text_valid   = out_data_r.text_valid;
  assign out_ch.text_byte    = out_data_r.text_byte;
  assign out_ch.arg_start    = out_data_r.arg_start;
  assign out_ch.arg_end      = out_data_r.arg_end;
  assign out_ch.unterminated = out_data_r.unterminated;
  assign out_ch.line_done    = out_data_r.line_done;
  assign out_ch.arg_count    = out_data_r.arg_count;

  `QAT_ASSERT_NOW(a_unterm_closes, out_valid_r && out_data_r.unterminated, out_data_r.arg_end && out_data_r.line_done, "unterminated without end of line")
  `QAT_ASSERT_NOW(a_start_counts, out_valid_r && out_data_r.arg_start, out_data_r.arg_count != 16'd0 && !out_data_r.line_done, "argument start with zero count")
  `QAT_ASSERT_NOW(a_eol_text, out_valid_r && out_data_r.line_done && out_data_r.text_valid, out_data_r.unterminated && out_data_r.text_byte == escape_r, "end of line text not a pending escape")
  `QAT_ASSERT_NEXT(a_stall_holds, out_valid_r && !out_ch.ready, out_valid_r && $stable(out_data_r), "stalled result changed")

endmodule
